// ===== rtl/core/vrr_pkg.sv =====
// Package for the versioned registry: command and status codes, payload structs.
// No dependencies.
`timescale 1ns / 1ps
package vrr_pkg;
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_ACQUIRE = 3'd1, CMD_RELEASE = 3'd2,
    CMD_FIND = 3'd3, CMD_RESOLVE = 3'd4, CMD_READ = 3'd5
  } cmd_t;
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_EXISTS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;
  localparam logic [31:0] REFS_MAX    = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_LIMIT = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [63:0]        name_key;
    logic signed [31:0] api_ver;
    logic signed [31:0] int_ver;
    logic [63:0]        proc_in;
    logic [63:0]        host_in;
    logic [5:0]         entry_select;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         entry_index;
    logic [63:0]        proc_out;
    logic [63:0]        host_out;
    logic [63:0]        name_out;
    logic signed [31:0] api_out;
    logic signed [31:0] internal_out;
    logic [30:0]        ref_count;
  } rsp_t;

  typedef struct packed {
    logic [63:0] name;
    logic [31:0] api;
    logic [31:0] internal;
    logic [63:0] handle;
    logic [63:0] host;
    logic [31:0] refs;
  } slot_t;
endpackage

// ===== rtl/core/vrr_slot_mem.sv =====
// Slot store of the registry: one synchronous memory, one write and one read port.
// Depends on vrr_pkg.
`timescale 1ns / 1ps
module vrr_slot_mem #(
  parameter int ENTRIES = 64,
  parameter int AW = 6
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  vrr_pkg::slot_t wdata,
  input  logic [AW-1:0]  raddr,
  output vrr_pkg::slot_t rdata
);
  vrr_pkg::slot_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/versioned_registry_refcount.sv =====
// Top level of the versioned registry: command sequencer around the slot store.
// Depends on vrr_pkg and vrr_slot_mem.
`timescale 1ns / 1ps
//  channel   | signals               | transfer
//  command   | start, busy, req      | start high while busy low
//  result    | done, rsp             | done high for one cycle
// Each command sweeps all ENTRIES slots through the single memory read port, one a
// cycle, then the states S_LAST, S_ACT, S_WAIT and S_OUT finish the sweep, fetch the chosen
// slot and form the answer: busy stays high from the accepting edge through S_OUT, the
// result follows in the next cycle, and a new command may be taken there.
// Reset clears the used bits and the sequencer; slot contents are not cleared.
// The result cannot be stalled; busy drops in the cycle that shows it.
module versioned_registry_refcount #(
  parameter int ENTRIES = 64,
  parameter int NAME_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  vrr_pkg::req_t req,
  output logic          done,
  output vrr_pkg::rsp_t rsp
);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_ACT, S_WAIT, S_OUT} state_t;
  state_t state;

  vrr_pkg::req_t   cur;
  logic [63:0]     tname;
  logic            nvalid, api_ok, int_ok;
  logic [ENTRIES-1:0] used;
  logic [CW-1:0]   rcnt;
  logic [AW-1:0]   pidx;
  logic            pvalid;
  logic            hit, free_found, res_found;
  logic [AW-1:0]   hit_idx, free_idx, res_idx;
  logic [31:0]     res_int;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  vrr_pkg::slot_t  wdata, rdata;

  vrr_slot_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [3:0] nlen;
  logic [63:0] key_mask;
  always_comb begin
    nlen = 4'd8;
    for (int b = 7; b >= 0; b--) begin
      if (req.name_key[8*b +: 8] == 8'd0) nlen = 4'(b);
    end
    key_mask = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < nlen) key_mask[8*b +: 8] = 8'hFF;
    end
  end

  logic eq_na, eq_full;
  assign eq_na = used[pidx] && rdata.name == tname &&
                 rdata.api == cur.api_ver;
  assign eq_full = eq_na && rdata.internal == cur.int_ver;
  assign raddr = (state == S_ACT || state == S_WAIT) ? (cur.cmd == vrr_pkg::CMD_READ ?
                 cur.entry_select[AW-1:0] : hit_idx) : rcnt[AW-1:0];

  logic sel_ok;
  assign sel_ok = ({26'd0, cur.entry_select} < 32'(ENTRIES)) &&
                  used[cur.entry_select[AW-1:0]];

  logic           we_next, add_ok;
  logic [AW-1:0]  waddr_next;
  vrr_pkg::slot_t wdata_next;
  vrr_pkg::rsp_t  rsp_next;

  always_comb begin
    rsp_next = '0;
    rsp_next.status = vrr_pkg::ST_BAD;
    wdata_next = rdata;
    waddr_next = hit_idx;
    we_next = 1'b0;
    add_ok = 1'b0;
    case (cur.cmd)
      vrr_pkg::CMD_ADD: begin
        if (nvalid && api_ok && int_ok && cur.proc_in != 64'd0) begin
          if (hit) rsp_next.status = vrr_pkg::ST_EXISTS;
          else if (free_found) begin
            rsp_next.status = vrr_pkg::ST_OK;
            rsp_next.entry_index = 6'(free_idx);
            add_ok = 1'b1;
            we_next = 1'b1;
            waddr_next = free_idx;
            wdata_next = '{name: tname, api: cur.api_ver,
                           internal: cur.int_ver,
                           handle: cur.proc_in, host: cur.host_in, refs: 32'd0};
          end
        end
      end
      vrr_pkg::CMD_ACQUIRE, vrr_pkg::CMD_RELEASE, vrr_pkg::CMD_FIND: begin
        if (nvalid && api_ok && int_ok) begin
          if (!hit) rsp_next.status = vrr_pkg::ST_NOTFOUND;
          else if (cur.cmd == vrr_pkg::CMD_FIND) begin
            rsp_next.status = vrr_pkg::ST_OK;
            rsp_next.entry_index = 6'(hit_idx);
          end else if (cur.cmd == vrr_pkg::CMD_ACQUIRE) begin
            if (rdata.refs != vrr_pkg::REFS_MAX) begin
              rsp_next.status = vrr_pkg::ST_OK;
              rsp_next.proc_out = rdata.handle;
              we_next = 1'b1;
              wdata_next.refs = rdata.refs + 32'd1;
            end
          end else if (rdata.refs == 32'd0) begin
            rsp_next.status = vrr_pkg::ST_RELEASED;
          end else begin
            rsp_next.status = vrr_pkg::ST_OK;
            we_next = 1'b1;
            wdata_next.refs = rdata.refs - 32'd1;
          end
        end
      end
      vrr_pkg::CMD_RESOLVE: begin
        if (nvalid && api_ok) begin
          if (!res_found) rsp_next.status = vrr_pkg::ST_NOTFOUND;
          else begin
            rsp_next.status = vrr_pkg::ST_OK;
            rsp_next.proc_out = rdata.handle;
          end
        end
      end
      vrr_pkg::CMD_READ: begin
        if (sel_ok) begin
          rsp_next.proc_out = rdata.handle;
          rsp_next.host_out = rdata.host;
          rsp_next.name_out = rdata.name;
          rsp_next.api_out = rdata.api;
          rsp_next.internal_out = rdata.internal;
          if (rdata.refs <= vrr_pkg::COUNT_LIMIT) begin
            rsp_next.status = vrr_pkg::ST_OK;
            rsp_next.ref_count = rdata.refs[30:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      used  <= '0;
      done  <= 1'b0;
      we    <= 1'b0;
    end else begin
      done <= state == S_OUT;
      we   <= state == S_OUT && we_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur    <= req;
            tname  <= req.name_key & key_mask;
            nvalid <= nlen != 4'd0 && 32'(nlen) <= NAME_BYTES;
            api_ok <= req.api_ver > 0;
            int_ok <= !req.int_ver[31];
            busy   <= 1'b1;
            rcnt   <= '0;
            pvalid <= 1'b0;
            hit <= 1'b0; free_found <= 1'b0; res_found <= 1'b0;
            hit_idx <= '0; free_idx <= '0; res_idx <= '0; res_int <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN, S_LAST: begin
          if (pvalid) begin
            if (eq_full && !hit) begin
              hit <= 1'b1; hit_idx <= pidx;
            end
            if (!used[pidx] && !free_found) begin
              free_found <= 1'b1; free_idx <= pidx;
            end
            if (eq_na && (!res_found || rdata.internal > res_int)) begin
              res_found <= 1'b1; res_idx <= pidx; res_int <= rdata.internal;
            end
          end
          pidx   <= rcnt[AW-1:0];
          pvalid <= state == S_SCAN;
          if (state == S_LAST) begin
            state <= S_ACT;
          end else begin
            if (rcnt == CW'(ENTRIES - 1)) state <= S_LAST;
            rcnt <= rcnt + 1'b1;
          end
        end
        S_ACT: begin
          if (cur.cmd == vrr_pkg::CMD_RESOLVE) hit_idx <= res_idx;
          state <= S_WAIT;
        end
        S_WAIT: begin
          state <= S_OUT;
        end
        S_OUT: begin
          rsp   <= rsp_next;
          wdata <= wdata_next;
          waddr <= waddr_next;
          if (add_ok) used[free_idx] <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/vrr_checker.sv =====
// Port checker for the versioned registry, bound to the top level.
// Depends on vrr_pkg and versioned_registry_refcount.
`timescale 1ns / 1ps
module vrr_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input vrr_pkg::rsp_t rsp
);
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted command did not raise busy");
  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy still high with result");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result shown twice");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.status <= vrr_pkg::ST_RELEASED) else $error("bad status code");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without command");
endmodule

bind versioned_registry_refcount vrr_checker u_vrr_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

// ===== tb/versioned_registry_refcount_tb.sv =====
// Self-checking testbench for versioned_registry_refcount (depends on vrr_pkg): a directed
// table, then random commands; typed rows are checked as written, the rest by a behavioural model.
`timescale 1ns / 1ps
module versioned_registry_refcount_tb;
  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    vrr_pkg::req_t r;
    bit            typed;
    vrr_pkg::rsp_t want;
  } row_t;

  logic clk, rst, start, busy, done;
  vrr_pkg::req_t req;
  vrr_pkg::rsp_t rsp;

  versioned_registry_refcount DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp)
  );

  bit          tbl_used [SLOTS];
  logic [63:0] tbl_name [SLOTS];
  logic [31:0] tbl_api [SLOTS];
  logic [31:0] tbl_internal [SLOTS];
  logic [63:0] tbl_handle [SLOTS];
  logic [63:0] tbl_host [SLOTS];
  logic [31:0] tbl_refs [SLOTS];

  vrr_pkg::rsp_t answers_due[$];
  row_t          directed[$];
  int            errors = 0;
  int            taken = 0;
  int            cycles = 0;
  bit            cur_typed;
  vrr_pkg::rsp_t cur_want;
  logic [63:0]   name_pool [6];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic bit trim_name(input logic [63:0] key, output logic [63:0] trimmed);
    int len;
    len = 0;
    while (len < 8 && key[8*len +: 8] != 8'h00) len++;
    trimmed = '0;
    for (int b = 0; b < len; b++) trimmed[8*b +: 8] = key[8*b +: 8];
    return len != 0;
  endfunction

  function automatic int match_slot(logic [63:0] nm, logic [31:0] api, logic [31:0] iv);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_used[i] && tbl_api[i] == api && tbl_internal[i] == iv && tbl_name[i] == nm)
        return i;
    return -1;
  endfunction

  function automatic vrr_pkg::rsp_t registry_answer(vrr_pkg::req_t r);
    vrr_pkg::rsp_t a;
    logic [63:0]   nm;
    logic [31:0]   api, iv;
    bit            nvalid, api_ok, basic_ok;
    int            hit;
    a = '0;
    a.status = vrr_pkg::ST_BAD;
    nvalid = trim_name(r.name_key, nm);
    api = r.api_ver;
    iv = r.int_ver;
    api_ok = api != 0 && !api[31];
    basic_ok = nvalid && api_ok && !iv[31];
    case (r.cmd)
      vrr_pkg::CMD_ADD: begin
        if (basic_ok && r.proc_in != 0) begin
          if (match_slot(nm, api, iv) >= 0) begin
            a.status = vrr_pkg::ST_EXISTS;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!tbl_used[i]) begin
                tbl_used[i] = 1;
                tbl_name[i] = nm;
                tbl_api[i] = api;
                tbl_internal[i] = iv;
                tbl_handle[i] = r.proc_in;
                tbl_host[i] = r.host_in;
                tbl_refs[i] = 0;
                a.status = vrr_pkg::ST_OK;
                a.entry_index = 6'(i);
                break;
              end
            end
          end
        end
      end
      vrr_pkg::CMD_ACQUIRE, vrr_pkg::CMD_RELEASE, vrr_pkg::CMD_FIND: begin
        if (basic_ok) begin
          hit = match_slot(nm, api, iv);
          if (hit < 0) begin
            a.status = vrr_pkg::ST_NOTFOUND;
          end else if (r.cmd == vrr_pkg::CMD_ACQUIRE) begin
            if (tbl_refs[hit] != vrr_pkg::REFS_MAX) begin
              tbl_refs[hit]++;
              a.proc_out = tbl_handle[hit];
              a.status = vrr_pkg::ST_OK;
            end
          end else if (r.cmd == vrr_pkg::CMD_RELEASE) begin
            if (tbl_refs[hit] == 0) begin
              a.status = vrr_pkg::ST_RELEASED;
            end else begin
              tbl_refs[hit]--;
              a.status = vrr_pkg::ST_OK;
            end
          end else begin
            a.entry_index = 6'(hit);
            a.status = vrr_pkg::ST_OK;
          end
        end
      end
      vrr_pkg::CMD_RESOLVE: begin
        if (nvalid && api_ok) begin
          hit = -1;
          for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_api[i] == api && tbl_name[i] == nm)
              if (hit < 0 || tbl_internal[i] > tbl_internal[hit]) hit = i;
          if (hit < 0) begin
            a.status = vrr_pkg::ST_NOTFOUND;
          end else begin
            a.proc_out = tbl_handle[hit];
            a.status = vrr_pkg::ST_OK;
          end
        end
      end
      vrr_pkg::CMD_READ: begin
        if (tbl_used[r.entry_select]) begin
          a.proc_out = tbl_handle[r.entry_select];
          a.host_out = tbl_host[r.entry_select];
          a.name_out = tbl_name[r.entry_select];
          a.api_out = tbl_api[r.entry_select];
          a.internal_out = tbl_internal[r.entry_select];
          if (tbl_refs[r.entry_select] <= vrr_pkg::COUNT_LIMIT) begin
            a.ref_count = tbl_refs[r.entry_select][30:0];
            a.status = vrr_pkg::ST_OK;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h, expected %h", cycles, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    vrr_pkg::rsp_t w, p;
    cycles <= cycles + 1;
    if (!rst && start && !busy) begin
      p = registry_answer(req);
      answers_due.insert(answers_due.size(), cur_typed ? cur_want : p);
      taken++;
    end
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        report("unexpected result", 64'd1, 64'd0);
      end else begin
        w = answers_due.pop_front();
        if (rsp.status !== w.status)
          report("status", 64'(rsp.status), 64'(w.status));
        if (rsp.entry_index !== w.entry_index)
          report("entry_index", 64'(rsp.entry_index), 64'(w.entry_index));
        if (rsp.proc_out !== w.proc_out) report("proc_out", rsp.proc_out, w.proc_out);
        if (rsp.host_out !== w.host_out) report("host_out", rsp.host_out, w.host_out);
        if (rsp.name_out !== w.name_out) report("name_out", rsp.name_out, w.name_out);
        if (rsp.api_out !== w.api_out)
          report("api_out", 64'($unsigned(rsp.api_out)), 64'($unsigned(w.api_out)));
        if (rsp.internal_out !== w.internal_out)
          report("internal_out", 64'($unsigned(rsp.internal_out)),
                 64'($unsigned(w.internal_out)));
        if (rsp.ref_count !== w.ref_count)
          report("ref_count", 64'(rsp.ref_count), 64'(w.ref_count));
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("versioned_registry_refcount regression: fail");
      $finish;
    end
  end

  function automatic vrr_pkg::req_t mk(vrr_pkg::cmd_t c, logic [63:0] nm, logic [31:0] api,
                                       logic [31:0] iv, logic [63:0] pr, logic [63:0] hs,
                                       logic [5:0] sel);
    vrr_pkg::req_t r;
    r.cmd = c;
    r.name_key = nm;
    r.api_ver = api;
    r.int_ver = iv;
    r.proc_in = pr;
    r.host_in = hs;
    r.entry_select = sel;
    return r;
  endfunction

  task automatic add_row(vrr_pkg::req_t r, bit typed, logic [2:0] st, logic [5:0] idx);
    row_t w;
    w.r = r;
    w.typed = typed;
    w.want = '0;
    w.want.status = st;
    w.want.entry_index = idx;
    directed.insert(directed.size(), w);
  endtask

  task automatic send(vrr_pkg::req_t r, bit typed, vrr_pkg::rsp_t want, int idle_pct);
    int goal;
    while ($urandom_range(99) < idle_pct) begin
      start = 0;
      @(negedge clk);
    end
    goal = taken + 1;
    req = r;
    cur_typed = typed;
    cur_want = want;
    start = 1;
    do @(negedge clk); while (taken < goal);
  endtask

  function automatic vrr_pkg::req_t random_command();
    vrr_pkg::req_t r;
    logic [287:0]  raw;
    int            k;
    r.name_key = name_pool[$urandom_range(5)];
    k = $urandom_range(9);
    r.api_ver = k < 5 ? 32'd1 : k < 8 ? 32'd2 : 32'h7FFF_FFFF;
    r.int_ver = $urandom_range(9) == 0 ? 32'h7FFF_FFFF : $urandom_range(3);
    r.proc_in = {$urandom, $urandom};
    r.host_in = {$urandom, $urandom};
    r.entry_select = 6'($urandom_range(63));
    k = $urandom_range(99);
    r.cmd = k < 30 ? vrr_pkg::CMD_ADD : k < 55 ? vrr_pkg::CMD_ACQUIRE :
            k < 75 ? vrr_pkg::CMD_RELEASE : k < 83 ? vrr_pkg::CMD_FIND :
            k < 91 ? vrr_pkg::CMD_RESOLVE : vrr_pkg::CMD_READ;
    if ($urandom_range(99) < 15) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      r = raw[$bits(vrr_pkg::req_t)-1:0];
      if ($urandom_range(3) == 0) r.name_key = name_pool[$urandom_range(5)];
    end
    return r;
  endfunction

  initial begin
    vrr_pkg::rsp_t none;
    int            pct;
    none = '0;
    name_pool[0] = 64'h61;
    name_pool[1] = 64'hFF00_0061;
    name_pool[2] = 64'h6F6C_6C65_68;
    name_pool[3] = 64'hFFFF_FFFF_FFFF_FFFF;
    name_pool[4] = 64'h0102_0304_0506_0708;
    name_pool[5] = 64'h8000_0000_0000_0080;
    rst = 1;
    start = 0;
    req = '0;
    cur_typed = 0;
    cur_want = '0;

    add_row(mk(vrr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0), 1, vrr_pkg::ST_BAD, 0);
    add_row(mk(vrr_pkg::CMD_ADD, 0, 1, 0, 1, 0, 0), 1, vrr_pkg::ST_BAD, 0);
    add_row(mk(vrr_pkg::CMD_ADD, 64'h61, 0, 0, 1, 0, 0), 1, vrr_pkg::ST_BAD, 0);
    add_row(mk(vrr_pkg::CMD_ADD, 64'h61, 32'h8000_0000, 0, 1, 0, 0), 1, vrr_pkg::ST_BAD, 0);
    add_row(mk(vrr_pkg::CMD_ADD, 64'h61, 1, 32'hFFFF_FFFF, 1, 0, 0), 1, vrr_pkg::ST_BAD, 0);
    add_row(mk(vrr_pkg::CMD_ADD, 64'h61, 1, 0, 0, 0, 0), 1, vrr_pkg::ST_BAD, 0);
    add_row(mk(vrr_pkg::CMD_ADD, 64'h61, 1, 0, '1, 0, 0), 1, vrr_pkg::ST_OK, 0);
    add_row(mk(vrr_pkg::CMD_ADD, 64'h61, 1, 0, 5, 0, 0), 1, vrr_pkg::ST_EXISTS, 0);
    add_row(mk(vrr_pkg::CMD_RELEASE, 64'h61, 1, 0, 0, 0, 0), 1, vrr_pkg::ST_RELEASED, 0);
    add_row(mk(vrr_pkg::CMD_FIND, 64'hFFFF_FF00_0061, 1, 0, 0, 0, 0), 0, vrr_pkg::ST_OK, 0);
    add_row(mk(vrr_pkg::CMD_ACQUIRE, 64'h61, 1, 0, 0, 0, 0), 0, vrr_pkg::ST_OK, 0);
    add_row(mk(vrr_pkg::CMD_ADD, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, '1, 0), 0,
            vrr_pkg::ST_OK, 0);
    add_row(mk(vrr_pkg::CMD_ADD, 64'h61, 1, 5, 64'hA5, 64'h5A, 0), 0, vrr_pkg::ST_OK, 0);
    add_row(mk(vrr_pkg::CMD_RESOLVE, 64'h61, 1, 32'hFFFF_FFF9, 0, 0, 0), 0,
            vrr_pkg::ST_OK, 0);
    add_row(mk(vrr_pkg::CMD_RESOLVE, 64'h62, 1, 0, 0, 0, 0), 1, vrr_pkg::ST_NOTFOUND, 0);
    add_row(mk(vrr_pkg::CMD_RESOLVE, 64'h61, 0, 0, 0, 0, 0), 1, vrr_pkg::ST_BAD, 0);
    add_row(mk(vrr_pkg::CMD_FIND, 64'h62, 1, 0, 0, 0, 0), 1, vrr_pkg::ST_NOTFOUND, 0);
    add_row(mk(vrr_pkg::CMD_READ, 0, 0, 0, 0, 0, 63), 1, vrr_pkg::ST_BAD, 0);
    add_row(mk(vrr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0), 0, vrr_pkg::ST_OK, 0);
    add_row(mk(vrr_pkg::CMD_READ, 0, 0, 0, 0, 0, 1), 0, vrr_pkg::ST_OK, 0);
    add_row(mk(vrr_pkg::CMD_RELEASE, 64'h61, 1, 0, 0, 0, 0), 0, vrr_pkg::ST_OK, 0);
    add_row(mk(vrr_pkg::cmd_t'(3'd6), 64'h61, 1, 0, 1, 0, 0), 1, vrr_pkg::ST_BAD, 0);
    add_row(mk(vrr_pkg::cmd_t'(3'd7), 64'h61, 1, 0, 1, 0, 0), 1, vrr_pkg::ST_BAD, 0);

    repeat (4) @(negedge clk);
    rst = 0;
    foreach (directed[i]) send(directed[i].r, directed[i].typed, directed[i].want, 0);
    for (int n = 0; n < 1100; n++) begin
      pct = n < 360 ? 10 : n < 720 ? 60 : 0;
      send(random_command(), 0, none, pct);
    end
    start = 0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("versioned_registry_refcount regression: pass");
    end else begin
      $display("versioned_registry_refcount regression: fail");
    end
    $finish;
  end
endmodule
